// ===== design/b128dd_pkg.sv =====
// Package for the binary to decimal digit converter: types, codes and constants.
`timescale 1ns / 1ps

package b128dd_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 128;
   localparam int HALF_WIDTH          = 64;
   localparam int CHAR_WIDTH          = 6;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture a new value, clear the digits
      logic dabble;      // one double-dabble step
      logic next_digit;  // drop the top digit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_last;    // counter at its final step
      logic digit_zero;  // top digit is zero
   } status_type;

endpackage

// ===== design/binary128_to_decimal_digits_unit.sv =====
// Top level: unsigned binary value to ASCII decimal digit stream.
//
//   channel | dir | contents
//   req     | in  | tdata[63:0] value_low, tdata[127:64] value_high
//   rsp     | out | tdata[5:0] digit_char (tdata[7:6] zero), tlast last_digit
//
// A value is converted by one double-dabble shift per bit, then by a
// leading-zero skip and output of the digits, one digit at a time.
// One value is converted at a time.
// Reset is synchronous; it returns the controller to idle.
// An output stall holds the current digit and halts progress.
`timescale 1ns / 1ps

module binary128_to_decimal_digits_unit #(
   parameter int VALUE_WIDTH = b128dd_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*b128dd_pkg::HALF_WIDTH-1:0] req_tdata,  // value_low, value_high
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // digit_char, 2 zero bits
   output logic                                rsp_tlast
);
   import b128dd_pkg::*;

   cmd_type                cmd;
   status_type             status;
   logic [CHAR_WIDTH-1:0]  digit_char;

   b128dd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   b128dd_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (req_tdata),
      .status     (status),
      .digit_char (digit_char)
   );

   assign rsp_tdata = {2'b00, digit_char};

endmodule

// ===== design/b128dd_dp.sv =====
// Datapath: double-dabble shift register, digit register and step counter.
`timescale 1ns / 1ps

module b128dd_dp #(
   parameter int VALUE_WIDTH = b128dd_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  b128dd_pkg::cmd_type                    cmd,
   input  logic [2*b128dd_pkg::HALF_WIDTH-1:0]    value,
   output b128dd_pkg::status_type                 status,
   output logic [b128dd_pkg::CHAR_WIDTH-1:0]      digit_char
);
   import b128dd_pkg::*;

   // decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 ~ log10 2)
   localparam int DIGITS = ((VALUE_WIDTH * 1233) / 4096) + 1;
   localparam int BCD_WIDTH = 4 * DIGITS;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [BCD_WIDTH-1:0]   adj;
   logic [3:0]             top;

   always_comb begin
      logic [3:0] nib;
      for (int g = 0; g < DIGITS; g++) begin
         nib = bcd_ff[4*g +: 4];
         adj[4*g +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   assign top = bcd_ff[BCD_WIDTH-1 -: 4];

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         bin_in = value[VALUE_WIDTH-1:0];
         bcd_in = '0;
         cnt_in = CW'(VALUE_WIDTH);
      end else if (cmd.dabble) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         cnt_in = status.cnt_last ? CW'(DIGITS) : cnt_ff - CW'(1);
      end else if (cmd.next_digit) begin
         bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         bcd_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         bcd_ff <= bcd_in;
      end
      bin_ff <= bin_in;
   end

   assign status.cnt_last   = (cnt_ff == CW'(1));
   assign status.digit_zero = (top == 4'd0);
   assign digit_char        = ASCII_ZERO + {2'b00, top};

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cnt_ff == CW'(VALUE_WIDTH))
      else $error("step counter not loaded with value width");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      top <= 4'd9)
      else $error("top digit out of decimal range");

   a_last_digits: assert property (@(posedge clock) disable iff (reset)
      cmd.dabble && status.cnt_last |=> cnt_ff == CW'(DIGITS))
      else $error("digit count not loaded after conversion");

endmodule

// ===== design/b128dd_ctrl.sv =====
// Controller: sequences load, conversion, leading-zero skip and digit output.
`timescale 1ns / 1ps

module b128dd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_tlast,
   input  b128dd_pkg::status_type  status,
   output b128dd_pkg::cmd_type     cmd
);
   import b128dd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.cnt_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!status.digit_zero || status.cnt_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && status.cnt_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      rsp_tlast      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
         end
         ST_SCAN: begin
            cmd.next_digit = status.digit_zero && !status.cnt_last;
         end
         ST_EMIT: begin
            rsp_tvalid     = 1'b1;
            rsp_tlast      = status.cnt_last;
            cmd.next_digit = rsp_tready && !status.cnt_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while digits still pending");

   a_conv_to_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT && status.cnt_last |=> state_ff == ST_SCAN)
      else $error("conversion did not end after final step");

   a_first_digit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !status.digit_zero || status.cnt_last)
      else $error("leading zero emitted");

endmodule
